// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the checker files.
// Clocked on the rising edge and disabled while the async reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every edge
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");

// cons must hold in the same cycle as ante
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- hdl/lfmc_pkg.sv -----
// Types, command codes and helper functions of the line follower motor controller.
// No dependencies; used by the top level and its checker.
package lfmc_pkg;

	// command characters
	localparam logic [7:0] CMD_AUTO     = 8'h41; // 'A'
	localparam logic [7:0] CMD_MANUAL   = 8'h4D; // 'M'
	localparam logic [7:0] CMD_SPEED_LO = 8'h31; // '1'
	localparam logic [7:0] CMD_SPEED_MD = 8'h32; // '2'
	localparam logic [7:0] CMD_SPEED_HI = 8'h33; // '3'
	localparam logic [7:0] CMD_FWD      = 8'h46; // 'F'
	localparam logic [7:0] CMD_BACK     = 8'h42; // 'B'
	localparam logic [7:0] CMD_LEFT     = 8'h4C; // 'L'
	localparam logic [7:0] CMD_RIGHT    = 8'h52; // 'R'
	localparam logic [7:0] CMD_STOP     = 8'h53; // 'S'

	localparam logic [7:0] DUTY_LO  = 8'd120;
	localparam logic [7:0] DUTY_MD  = 8'd180;
	localparam logic [7:0] DUTY_HI  = 8'd230;
	localparam logic [7:0] DUTY_MAX = 8'd255;

	localparam logic [7:0]  BASE_SPEED_RST = 8'd115;
	localparam logic [7:0]  TURN_SPEED_RST = 8'd100;
	localparam logic [7:0]  GAIN_RST       = 8'd60;
	localparam logic [15:0] LOST_LIMIT_RST = 16'd1500;
	localparam logic [15:0] LOST_MAX       = 16'hFFFF;

	typedef enum logic [1:0] {
		REG_BASE_SPEED = 2'd0,
		REG_TURN_SPEED = 2'd1,
		REG_GAIN       = 2'd2,
		REG_LOST_LIMIT = 2'd3
	} reg_idx_t;

	// direction pins, left_back in bit 0
	typedef struct packed {
		logic right_back;
		logic right_fwd;
		logic left_fwd;
		logic left_back;
	} pins_t;

	localparam pins_t PINS_STOP  = '{right_back: 1'b0, right_fwd: 1'b0,
		left_fwd: 1'b0, left_back: 1'b0};
	localparam pins_t PINS_FWD   = '{right_back: 1'b0, right_fwd: 1'b1,
		left_fwd: 1'b1, left_back: 1'b0};
	localparam pins_t PINS_BACK  = '{right_back: 1'b1, right_fwd: 1'b0,
		left_fwd: 1'b0, left_back: 1'b1};
	localparam pins_t PINS_LEFT  = '{right_back: 1'b0, right_fwd: 1'b1,
		left_fwd: 1'b0, left_back: 1'b1};
	localparam pins_t PINS_RIGHT = '{right_back: 1'b1, right_fwd: 1'b0,
		left_fwd: 1'b1, left_back: 1'b0};

	// result tdata layout
	localparam int OUT_LDUTY_LSB = 0;
	localparam int OUT_RDUTY_LSB = 8;
	localparam int OUT_PINS_LSB  = 16;
	localparam int OUT_AUTO_BIT  = 20;
	localparam int OUT_DATA_W    = 24;

	// pivot pins; a zero turn duty leaves both motors on forward pins
	function automatic pins_t pivot_pins(input logic toward_left, input logic turn_zero);
		pins_t p;
		if (turn_zero) begin
			p = PINS_FWD;
		end else if (toward_left) begin
			p = PINS_LEFT;
		end else begin
			p = PINS_RIGHT;
		end
		return p;
	endfunction

	function automatic logic [7:0] clamp_duty(input logic signed [9:0] v);
		logic [7:0] d;
		if (v < 10'sd0) begin
			d = 8'd0;
		end else if (v > 10'sd255) begin
			d = DUTY_MAX;
		end else begin
			d = v[7:0];
		end
		return d;
	endfunction

endpackage

// ----- hdl/line_follower_motor_controller_top.sv -----
// Line follower motor controller: command decode, line decode and motor drive.
// Depends on lfmc_pkg.
//
//  channel   dir  handshake                 contents
//  s_axis    in   tvalid/tready             one control tick (command + sensors)
//  m_axis    out  tvalid/tready             motor duties, direction pins, mode
//  apb       in   psel/penable/pwrite/pready base_speed, turn_speed, gain, lost_limit
//
// One request per clock unless m_axis stalls; path: input register, then result register.
// All controller state is one register set, updated when a tick enters the result register.
// Reset: auto mode, not started, manual duty 180, duties zero, pins low, registers at defaults.
// A stalled m_axis holds its result; the input register still takes one more request.
module line_follower_motor_controller_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // cmd_byte[7:0], left_seen, center_seen, right_seen, pad
	input  logic        s_axis_tuser,  // cmd_valid
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // left_duty[7:0], right_duty[7:0], left_back_pin,
	                                   // left_fwd_pin, right_fwd_pin, right_back_pin, in_auto, pad
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// configuration
	logic [7:0]  base_speed_q;
	logic [7:0]  turn_speed_q;
	logic [7:0]  gain_q;
	logic [15:0] lost_limit_q;
	lfmc_pkg::reg_idx_t reg_idx;

	// input stage
	logic        valid_s1;
	logic        cmd_valid_s1;
	logic [7:0]  cmd_byte_s1;
	logic [2:0]  sens_s1;     // {left, center, right}
	logic        advance;

	// controller state
	logic              auto_q;
	logic              started_q;
	logic [15:0]       lost_count_q;
	logic signed [2:0] prev_err_q;
	logic [7:0]        manual_duty_q;
	logic [7:0]        lduty_q;
	logic [7:0]        rduty_q;
	lfmc_pkg::pins_t   pins_q;

	logic              auto_d;
	logic              started_d;
	logic [15:0]       lost_count_d;
	logic signed [2:0] prev_err_d;
	logic [7:0]        manual_duty_d;
	logic [7:0]        lduty_d;
	logic [7:0]        rduty_d;
	lfmc_pkg::pins_t   pins_d;

	logic              out_valid_q;
	logic [23:0]       out_data_q;

	logic [15:0]       lost_inc;
	logic signed [2:0] err;
	logic              hard;
	logic signed [9:0] sum_plus;
	logic signed [9:0] sum_minus;
	logic              cfg_wr;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign reg_idx = lfmc_pkg::reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_speed_q <= lfmc_pkg::BASE_SPEED_RST;
			turn_speed_q <= lfmc_pkg::TURN_SPEED_RST;
			gain_q       <= lfmc_pkg::GAIN_RST;
			lost_limit_q <= lfmc_pkg::LOST_LIMIT_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				lfmc_pkg::REG_BASE_SPEED: base_speed_q <= pwdata[7:0];
				lfmc_pkg::REG_TURN_SPEED: turn_speed_q <= pwdata[7:0];
				lfmc_pkg::REG_GAIN:       gain_q       <= pwdata[7:0];
				lfmc_pkg::REG_LOST_LIMIT: lost_limit_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			lfmc_pkg::REG_BASE_SPEED: prdata = {24'd0, base_speed_q};
			lfmc_pkg::REG_TURN_SPEED: prdata = {24'd0, turn_speed_q};
			lfmc_pkg::REG_GAIN:       prdata = {24'd0, gain_q};
			lfmc_pkg::REG_LOST_LIMIT: prdata = {16'd0, lost_limit_q};
			default:                  prdata = 32'd0;
		endcase
	end

	// pipeline control
	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			cmd_valid_s1 <= s_axis_tuser;
			cmd_byte_s1  <= s_axis_tdata[7:0];
			sens_s1      <= {s_axis_tdata[8], s_axis_tdata[9], s_axis_tdata[10]};
		end
	end

	// line decode
	always_comb begin
		case (sens_s1)
			3'b110:  begin err = -3'sd1; hard = 1'b0; end
			3'b011:  begin err =  3'sd1; hard = 1'b0; end
			3'b100:  begin err = -3'sd2; hard = 1'b1; end
			3'b001:  begin err =  3'sd2; hard = 1'b1; end
			default: begin err =  3'sd0; hard = 1'b0; end
		endcase
	end

	// gain times a soft error of -1, 0 or +1 reduces to add/subtract
	assign sum_plus  = $signed({2'b00, base_speed_q}) + $signed({2'b00, gain_q});
	assign sum_minus = $signed({2'b00, base_speed_q}) - $signed({2'b00, gain_q});
	assign lost_inc  = (lost_count_q == lfmc_pkg::LOST_MAX) ? lost_count_q
		: lost_count_q + 16'd1;

	always_comb begin
		auto_d        = auto_q;
		started_d     = started_q;
		lost_count_d  = lost_count_q;
		prev_err_d    = prev_err_q;
		manual_duty_d = manual_duty_q;
		lduty_d       = lduty_q;
		rduty_d       = rduty_q;
		pins_d        = pins_q;

		if (cmd_valid_s1) begin
			if (cmd_byte_s1 == lfmc_pkg::CMD_AUTO) begin
				auto_d    = 1'b1;
				started_d = 1'b0;
			end
			if (cmd_byte_s1 == lfmc_pkg::CMD_MANUAL) begin
				auto_d    = 1'b0;
				started_d = 1'b0;
				pins_d    = lfmc_pkg::PINS_STOP;
			end
			if (!auto_d) begin
				case (cmd_byte_s1)
					lfmc_pkg::CMD_SPEED_LO: manual_duty_d = lfmc_pkg::DUTY_LO;
					lfmc_pkg::CMD_SPEED_MD: manual_duty_d = lfmc_pkg::DUTY_MD;
					lfmc_pkg::CMD_SPEED_HI: manual_duty_d = lfmc_pkg::DUTY_HI;
					lfmc_pkg::CMD_FWD: begin
						lduty_d = manual_duty_q;
						rduty_d = manual_duty_q;
						pins_d  = lfmc_pkg::PINS_FWD;
					end
					lfmc_pkg::CMD_BACK: begin
						lduty_d = manual_duty_q;
						rduty_d = manual_duty_q;
						pins_d  = lfmc_pkg::PINS_BACK;
					end
					lfmc_pkg::CMD_LEFT: begin
						lduty_d = manual_duty_q;
						rduty_d = manual_duty_q;
						pins_d  = lfmc_pkg::PINS_LEFT;
					end
					lfmc_pkg::CMD_RIGHT: begin
						lduty_d = manual_duty_q;
						rduty_d = manual_duty_q;
						pins_d  = lfmc_pkg::PINS_RIGHT;
					end
					lfmc_pkg::CMD_STOP: pins_d = lfmc_pkg::PINS_STOP;
					default: ;
				endcase
			end
		end

		if (auto_d) begin
			if (sens_s1 != 3'b000) begin
				started_d    = 1'b1;
				lost_count_d = 16'd0;
				prev_err_d   = err;
				if (hard) begin
					lduty_d = turn_speed_q;
					rduty_d = turn_speed_q;
					pins_d  = lfmc_pkg::pivot_pins(err < 3'sd0, turn_speed_q == 8'd0);
				end else begin
					case (err)
						3'sd1: begin
							lduty_d = lfmc_pkg::clamp_duty(sum_plus);
							rduty_d = lfmc_pkg::clamp_duty(sum_minus);
						end
						-3'sd1: begin
							lduty_d = lfmc_pkg::clamp_duty(sum_minus);
							rduty_d = lfmc_pkg::clamp_duty(sum_plus);
						end
						default: begin
							lduty_d = base_speed_q;
							rduty_d = base_speed_q;
						end
					endcase
					pins_d = lfmc_pkg::PINS_FWD;
				end
			end else if (!started_d) begin
				pins_d = lfmc_pkg::PINS_STOP;
			end else begin
				// line lost: search toward the last error until the limit
				lost_count_d = lost_inc;
				if (lost_inc < lost_limit_q) begin
					lduty_d = turn_speed_q;
					rduty_d = turn_speed_q;
					pins_d  = lfmc_pkg::pivot_pins(prev_err_q <= 3'sd0,
						turn_speed_q == 8'd0);
				end else begin
					pins_d    = lfmc_pkg::PINS_STOP;
					started_d = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			auto_q        <= 1'b1;
			started_q     <= 1'b0;
			lost_count_q  <= 16'd0;
			prev_err_q    <= 3'sd0;
			manual_duty_q <= lfmc_pkg::DUTY_MD;
			lduty_q       <= 8'd0;
			rduty_q       <= 8'd0;
			pins_q        <= lfmc_pkg::PINS_STOP;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				auto_q        <= auto_d;
				started_q     <= started_d;
				lost_count_q  <= lost_count_d;
				prev_err_q    <= prev_err_d;
				manual_duty_q <= manual_duty_d;
				lduty_q       <= lduty_d;
				rduty_q       <= rduty_d;
				pins_q        <= pins_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_data_q <= {3'b000, auto_d, pins_d, rduty_d, lduty_d};
		end
	end

endmodule

// ----- hdl/lfmc_checker.sv -----
// Port-level checks of the line follower motor controller, bound to the top level.
// Depends on lfmc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lfmc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata
);

	lfmc_pkg::pins_t pins;
	logic [7:0]      lduty;
	logic [7:0]      rduty;
	logic            reverse;

	assign pins    = lfmc_pkg::pins_t'(m_axis_tdata[lfmc_pkg::OUT_PINS_LSB +: 4]);
	assign lduty   = m_axis_tdata[lfmc_pkg::OUT_LDUTY_LSB +: 8];
	assign rduty   = m_axis_tdata[lfmc_pkg::OUT_RDUTY_LSB +: 8];
	assign reverse = pins.left_back | pins.right_back;

	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	`ASSERT_NEXT(a_out_stable, clk, arst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
	// a motor is never driven forward and backward at once
	`ASSERT_IMPL(a_no_shoot, clk, arst_n, m_axis_tvalid, !(pins.left_back && pins.left_fwd) && !(pins.right_back && pins.right_fwd))
	// any reversed motor comes from a manual drive or a pivot, both of which use one duty
	`ASSERT_IMPL(a_rev_equal, clk, arst_n, m_axis_tvalid && reverse, lduty == rduty)

endmodule

bind line_follower_motor_controller_top lfmc_checker u_lfmc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// ----- test/line_follower_motor_controller_top_test.sv -----
// Self-checking bench for line_follower_motor_controller_top: directed ticks, then random ticks.
// Keeps its own model of the controller and scoreboards every result; uses lfmc_pkg.
`timescale 1ns / 100ps

module line_follower_motor_controller_top_test;

	localparam logic [7:0] CMD_SPIN = 8'h47; // 'G', not supported, must be ignored
	localparam int         STALL_LIMIT = 2000;
	localparam int         IDLE_PCT = 25;

	// sensor patterns {left, center, right}
	localparam logic [2:0] SEN_WHITE = 3'b000;
	localparam logic [2:0] SEN_ALL   = 3'b111;
	localparam logic [2:0] SEN_LC    = 3'b110;
	localparam logic [2:0] SEN_CR    = 3'b011;
	localparam logic [2:0] SEN_L     = 3'b100;
	localparam logic [2:0] SEN_R     = 3'b001;
	localparam logic [2:0] SEN_LR    = 3'b101;
	localparam logic [2:0] SEN_C     = 3'b010;

	// same layout as m_axis_tdata[20:0]
	typedef struct packed {
		logic            in_auto;
		lfmc_pkg::pins_t pins;
		logic [7:0]      rdc;
		logic [7:0]      ldc;
	} drive_t;

	typedef struct {
		logic       cv;
		logic [7:0] cmd;
		logic [2:0] sens;
		logic       chk;   // use the typed-in result instead of the model
		drive_t     want;
	} tick_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic        s_axis_tuser = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	line_follower_motor_controller_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	// controller model state
	logic [7:0]      cfg_base, cfg_turn, cfg_gain;
	logic [15:0]     cfg_lost;
	logic            st_auto, st_started;
	logic [15:0]     st_lost;
	int              st_err;
	logic [7:0]      st_man_duty, st_ldc, st_rdc;
	lfmc_pkg::pins_t st_pins;

	drive_t motor_due[$];
	tick_t  dir_tab[$];
	int     bad_results = 0;
	int     stall_cycles = 0;
	int     white_run = 0;
	logic   calm = 1'b0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [7:0] sat_duty(input int v);
		if (v < 0)
			return 8'd0;
		if (v > 255)
			return lfmc_pkg::DUTY_MAX;
		return v[7:0];
	endfunction

	task automatic spin(input logic toward_left);
		st_ldc = cfg_turn;
		st_rdc = cfg_turn;
		if (cfg_turn == 8'd0)
			st_pins = lfmc_pkg::PINS_FWD;
		else
			st_pins = toward_left ? lfmc_pkg::PINS_LEFT : lfmc_pkg::PINS_RIGHT;
	endtask

	// one control tick of the model; returns the state seen on the outputs
	task automatic steer_tick(input tick_t t, output drive_t d);
		int  err;
		logic hard;
		err = 0;
		hard = 1'b0;
		if (t.cv) begin
			if (t.cmd == lfmc_pkg::CMD_AUTO) begin
				st_auto = 1'b1;
				st_started = 1'b0;
			end
			if (t.cmd == lfmc_pkg::CMD_MANUAL) begin
				st_auto = 1'b0;
				st_started = 1'b0;
				st_pins = lfmc_pkg::PINS_STOP;
			end
			if (!st_auto) begin
				case (t.cmd)
				lfmc_pkg::CMD_SPEED_LO: st_man_duty = lfmc_pkg::DUTY_LO;
				lfmc_pkg::CMD_SPEED_MD: st_man_duty = lfmc_pkg::DUTY_MD;
				lfmc_pkg::CMD_SPEED_HI: st_man_duty = lfmc_pkg::DUTY_HI;
				lfmc_pkg::CMD_FWD, lfmc_pkg::CMD_BACK, lfmc_pkg::CMD_LEFT,
				lfmc_pkg::CMD_RIGHT: begin
					st_ldc = st_man_duty;
					st_rdc = st_man_duty;
					st_pins = (t.cmd == lfmc_pkg::CMD_FWD) ? lfmc_pkg::PINS_FWD :
						(t.cmd == lfmc_pkg::CMD_BACK) ? lfmc_pkg::PINS_BACK :
						(t.cmd == lfmc_pkg::CMD_LEFT) ? lfmc_pkg::PINS_LEFT :
						lfmc_pkg::PINS_RIGHT;
				end
				lfmc_pkg::CMD_STOP: st_pins = lfmc_pkg::PINS_STOP;
				default: ;
				endcase
			end
		end
		if (st_auto) begin
			if (t.sens == SEN_WHITE) begin
				if (!st_started) begin
					st_pins = lfmc_pkg::PINS_STOP;
				end else begin
					if (st_lost != lfmc_pkg::LOST_MAX)
						st_lost = st_lost + 16'd1;
					if (st_lost < cfg_lost) begin
						spin(st_err <= 0);
					end else begin
						st_pins = lfmc_pkg::PINS_STOP;
						st_started = 1'b0;
					end
				end
			end else begin
				st_started = 1'b1;
				st_lost = '0;
				case (t.sens)
				SEN_LC: err = -1;
				SEN_CR: err = 1;
				SEN_L: begin
					err = -2;
					hard = 1'b1;
				end
				SEN_R: begin
					err = 2;
					hard = 1'b1;
				end
				default: err = 0;
				endcase
				st_err = err;
				if (hard) begin
					spin(err < 0);
				end else begin
					st_ldc = sat_duty(int'(cfg_base) + int'(cfg_gain) * err);
					st_rdc = sat_duty(int'(cfg_base) - int'(cfg_gain) * err);
					st_pins = lfmc_pkg::PINS_FWD;
				end
			end
		end
		d.ldc = st_ldc;
		d.rdc = st_rdc;
		d.pins = st_pins;
		d.in_auto = st_auto;
	endtask

	task automatic send_tick(input tick_t t);
		drive_t d;
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= t.cv;
		s_axis_tdata <= {5'd0, t.sens[0], t.sens[1], t.sens[2], t.cmd};
		do @(negedge clk); while (!s_axis_tready);
		@(posedge clk);
		steer_tick(t, d);
		motor_due.push_back(t.chk ? t.want : d);
	endtask

	// wait until every result is back and the pipeline is empty
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (motor_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_write(input lfmc_pkg::reg_idx_t idx, input logic [31:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(negedge clk); while (!pready);
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
		lfmc_pkg::REG_BASE_SPEED: cfg_base = v[7:0];
		lfmc_pkg::REG_TURN_SPEED: cfg_turn = v[7:0];
		lfmc_pkg::REG_GAIN:       cfg_gain = v[7:0];
		lfmc_pkg::REG_LOST_LIMIT: cfg_lost = v[15:0];
		default: ;
		endcase
		// leave the bus idle before the next request
		@(posedge clk);
	endtask

	task automatic set_regs(input logic [7:0] b, input logic [7:0] tu, input logic [7:0] g,
		input logic [15:0] lim);
		drain();
		apb_write(lfmc_pkg::REG_BASE_SPEED, {24'd0, b});
		apb_write(lfmc_pkg::REG_TURN_SPEED, {24'd0, tu});
		apb_write(lfmc_pkg::REG_GAIN, {24'd0, g});
		apb_write(lfmc_pkg::REG_LOST_LIMIT, {16'd0, lim});
	endtask

	task automatic add_row(input logic cv, input logic [7:0] cmd, input logic [2:0] sens,
		input logic chk, input logic [7:0] ld, input logic [7:0] rd,
		input lfmc_pkg::pins_t p, input logic au);
		tick_t t;
		t.cv = cv;
		t.cmd = cmd;
		t.sens = sens;
		t.chk = chk;
		t.want.ldc = ld;
		t.want.rdc = rd;
		t.want.pins = p;
		t.want.in_auto = au;
		dir_tab.push_back(t);
	endtask

	// random ticks: a quarter carry a command; white runs long enough to hit the lost limit
	task automatic run_random(input int n);
		tick_t t;
		int    pick;
		int    run_cap;
		for (int k = 0; k < n; k++) begin
			t.chk = 1'b0;
			t.want = '0;
			t.cv = ($urandom_range(99) < 25);
			pick = $urandom_range(99);
			if (pick < 4) begin
				t.cmd = lfmc_pkg::CMD_AUTO;
			end else if (pick < 8) begin
				t.cmd = lfmc_pkg::CMD_MANUAL;
			end else if (pick < 85) begin
				case ($urandom_range(8))
				0: t.cmd = lfmc_pkg::CMD_SPEED_LO;
				1: t.cmd = lfmc_pkg::CMD_SPEED_MD;
				2: t.cmd = lfmc_pkg::CMD_SPEED_HI;
				3: t.cmd = lfmc_pkg::CMD_FWD;
				4: t.cmd = lfmc_pkg::CMD_BACK;
				5: t.cmd = lfmc_pkg::CMD_LEFT;
				6: t.cmd = lfmc_pkg::CMD_RIGHT;
				7: t.cmd = lfmc_pkg::CMD_STOP;
				default: t.cmd = CMD_SPIN;
				endcase
			end else begin
				t.cmd = 8'($urandom_range(255));
			end
			run_cap = (cfg_lost < 16'd20) ? int'(cfg_lost) + 2 : 20;
			if (white_run != 0) begin
				t.sens = SEN_WHITE;
				white_run--;
			end else if ($urandom_range(99) < 8) begin
				t.sens = SEN_WHITE;
				white_run = $urandom_range(run_cap, 1);
			end else begin
				t.sens = 3'($urandom_range(7));
			end
			send_tick(t);
		end
	endtask

	initial begin
		cfg_base = lfmc_pkg::BASE_SPEED_RST;
		cfg_turn = lfmc_pkg::TURN_SPEED_RST;
		cfg_gain = lfmc_pkg::GAIN_RST;
		cfg_lost = lfmc_pkg::LOST_LIMIT_RST;
		st_auto = 1'b1;
		st_started = 1'b0;
		st_lost = '0;
		st_err = 0;
		st_man_duty = lfmc_pkg::DUTY_MD;
		st_ldc = '0;
		st_rdc = '0;
		st_pins = lfmc_pkg::PINS_STOP;

		// auto mode with default registers
		add_row(1'b0, 8'h00, SEN_WHITE, 1'b1, 8'd0, 8'd0, lfmc_pkg::PINS_STOP, 1'b1);
		add_row(1'b0, 8'hFF, SEN_ALL, 1'b1, 8'd115, 8'd115, lfmc_pkg::PINS_FWD, 1'b1);
		add_row(1'b0, 8'h00, SEN_LC, 1'b1, 8'd55, 8'd175, lfmc_pkg::PINS_FWD, 1'b1);
		add_row(1'b0, 8'h00, SEN_CR, 1'b1, 8'd175, 8'd55, lfmc_pkg::PINS_FWD, 1'b1);
		add_row(1'b0, 8'h00, SEN_L, 1'b1, 8'd100, 8'd100, lfmc_pkg::PINS_LEFT, 1'b1);
		add_row(1'b0, 8'h00, SEN_R, 1'b1, 8'd100, 8'd100, lfmc_pkg::PINS_RIGHT, 1'b1);
		// line lost after a right error: recover to the right
		add_row(1'b0, 8'h00, SEN_WHITE, 1'b1, 8'd100, 8'd100, lfmc_pkg::PINS_RIGHT, 1'b1);
		add_row(1'b0, 8'h00, SEN_LR, 1'b1, 8'd115, 8'd115, lfmc_pkg::PINS_FWD, 1'b1);
		add_row(1'b0, 8'h00, SEN_C, 1'b1, 8'd115, 8'd115, lfmc_pkg::PINS_FWD, 1'b1);
		add_row(1'b0, 8'h00, SEN_WHITE, 1'b1, 8'd100, 8'd100, lfmc_pkg::PINS_LEFT, 1'b1);
		// manual commands are ignored in auto mode
		add_row(1'b1, lfmc_pkg::CMD_FWD, SEN_C, 1'b1, 8'd115, 8'd115,
			lfmc_pkg::PINS_FWD, 1'b1);
		// manual mode
		add_row(1'b1, lfmc_pkg::CMD_MANUAL, SEN_ALL, 1'b1, 8'd115, 8'd115,
			lfmc_pkg::PINS_STOP, 1'b0);
		add_row(1'b1, lfmc_pkg::CMD_SPEED_LO, SEN_WHITE, 1'b1, 8'd115, 8'd115,
			lfmc_pkg::PINS_STOP, 1'b0);
		add_row(1'b1, lfmc_pkg::CMD_FWD, SEN_WHITE, 1'b1, 8'd120, 8'd120,
			lfmc_pkg::PINS_FWD, 1'b0);
		add_row(1'b1, lfmc_pkg::CMD_SPEED_HI, SEN_WHITE, 1'b0, '0, '0,
			lfmc_pkg::PINS_STOP, 1'b0);
		add_row(1'b1, lfmc_pkg::CMD_BACK, SEN_WHITE, 1'b1, 8'd230, 8'd230,
			lfmc_pkg::PINS_BACK, 1'b0);
		add_row(1'b1, lfmc_pkg::CMD_SPEED_MD, SEN_LC, 1'b0, '0, '0,
			lfmc_pkg::PINS_STOP, 1'b0);
		add_row(1'b1, lfmc_pkg::CMD_LEFT, SEN_WHITE, 1'b1, 8'd180, 8'd180,
			lfmc_pkg::PINS_LEFT, 1'b0);
		add_row(1'b1, lfmc_pkg::CMD_RIGHT, SEN_WHITE, 1'b1, 8'd180, 8'd180,
			lfmc_pkg::PINS_RIGHT, 1'b0);
		add_row(1'b1, CMD_SPIN, SEN_R, 1'b0, '0, '0, lfmc_pkg::PINS_STOP, 1'b0);
		add_row(1'b0, lfmc_pkg::CMD_STOP, SEN_WHITE, 1'b0, '0, '0,
			lfmc_pkg::PINS_STOP, 1'b0);
		// stop leaves the duties alone
		add_row(1'b1, lfmc_pkg::CMD_STOP, SEN_ALL, 1'b1, 8'd180, 8'd180,
			lfmc_pkg::PINS_STOP, 1'b0);
		add_row(1'b1, lfmc_pkg::CMD_AUTO, SEN_WHITE, 1'b1, 8'd180, 8'd180,
			lfmc_pkg::PINS_STOP, 1'b1);
		add_row(1'b1, lfmc_pkg::CMD_MANUAL, SEN_CR, 1'b0, '0, '0,
			lfmc_pkg::PINS_STOP, 1'b0);
		add_row(1'b1, lfmc_pkg::CMD_AUTO, SEN_CR, 1'b1, 8'd175, 8'd55,
			lfmc_pkg::PINS_FWD, 1'b1);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = 0; k < dir_tab.size(); k++)
			send_tick(dir_tab[k]);

		// saturating duties, stop on the first white tick
		set_regs(8'd255, 8'd255, 8'd255, 16'd0);
		run_random(100);
		// zero turn speed pivots on forward pins
		set_regs(8'd0, 8'd0, 8'd0, 16'd1);
		run_random(100);
		set_regs(8'($urandom_range(255)), 8'($urandom_range(255, 1)), 8'($urandom_range(255)),
			16'd4);
		run_random(100);
		set_regs(8'($urandom_range(255)), 8'($urandom_range(255, 1)), 8'($urandom_range(255)),
			16'($urandom_range(6, 2)));
		run_random(100);

		// no idling from here on
		calm = 1'b1;
		set_regs(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
			16'($urandom_range(12, 2)));
		run_random(100);

		drain();
		repeat (8) @(posedge clk);
		bad_results = bad_results + motor_due.size();
		if (bad_results == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// result sink, scoreboard and stall watchdog
	always @(posedge clk) begin
		drive_t got;
		drive_t want;
		logic   diff;
		m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata[20:0];
				if (motor_due.size() == 0) begin
					bad_results++;
					if (bad_results <= 10)
						$display("%0t: result with no request pending: %h", $realtime, got);
				end else begin
					want = motor_due.pop_front();
					diff = (got.ldc !== want.ldc) || (got.rdc !== want.rdc) ||
						(got.pins.left_back !== want.pins.left_back) ||
						(got.pins.left_fwd !== want.pins.left_fwd) ||
						(got.pins.right_fwd !== want.pins.right_fwd) ||
						(got.pins.right_back !== want.pins.right_back) ||
						(got.in_auto !== want.in_auto);
					if (diff) begin
						bad_results++;
						if (bad_results <= 10) begin
							$write("%0t: exp duty %0d/%0d pins lb%b lf%b rf%b rb%b auto %b, ",
								$realtime, want.ldc, want.rdc, want.pins.left_back,
								want.pins.left_fwd, want.pins.right_fwd,
								want.pins.right_back, want.in_auto);
							$display("got duty %0d/%0d pins lb%b lf%b rf%b rb%b auto %b",
								got.ldc, got.rdc, got.pins.left_back,
								got.pins.left_fwd, got.pins.right_fwd,
								got.pins.right_back, got.in_auto);
						end
					end
				end
			end
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(psel && penable && pwrite && pready)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
				if (stall_cycles >= STALL_LIMIT) begin
					$display("SCOREBOARD MISMATCH");
					$finish;
				end
			end
		end
	end

endmodule
